@@ hdl/bpc_pkg.sv @@
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

  localparam logic [CfgWidth-1:0] DebounceTicksRst  = CfgWidth'(30);
  localparam logic [CfgWidth-1:0] LongPressTicksRst = CfgWidth'(5000);
  localparam logic [CfgWidth-1:0] ShortFbTicksRst   = CfgWidth'(1200);

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_DEBOUNCE_TICKS   = 2'd0,
    CFG_LONG_PRESS_TICKS = 2'd1,
    CFG_SHORT_FB_TICKS   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic ready_req;
    logic pin_level;
  } bpc_in_t;

  typedef struct packed {
    logic pressed;
    logic edge_res;
    logic short_press;
    logic long_press;
    logic from_fallback;
  } bpc_out_t;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_ticks;
    logic [CfgWidth-1:0] long_press_ticks;
    logic [CfgWidth-1:0] short_fallback_ticks;
  } bpc_cfg_t;

  typedef struct packed {
    logic                  debounced_pressed;
    logic                  debounce_active;
    logic [CountWidth-1:0] debounce_elapsed;
    logic                  hold_active;
    logic [CountWidth-1:0] hold_elapsed;
    logic                  action_done;
  } bpc_state_t;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    sat_inc = (v == CountMax) ? CountMax : v + CountWidth'(1);
  endfunction

endpackage

@@ hdl/bpc_step.sv @@
`timescale 1ns / 1ps

module bpc_step
  import bpc_pkg::*;
(
  input  bpc_cfg_t   cfg_i,
  input  bpc_state_t state_i,
  input  bpc_in_t    in_i,
  output bpc_state_t state_o,
  output bpc_out_t   out_o
);

  logic pin_down;
  logic edge_fire;
  logic short_fire;
  logic long_fire;
  logic fb_fire;
  bpc_state_t st;

  assign pin_down = ~in_i.pin_level;

  always_comb begin
    st         = state_i;
    edge_fire  = 1'b0;
    short_fire = 1'b0;
    long_fire  = 1'b0;
    fb_fire    = 1'b0;

    if (!in_i.ready_req) begin
      st = '0;
    end else begin
      if (st.hold_active) begin
        st.hold_elapsed = sat_inc(st.hold_elapsed);
      end

      if (pin_down != st.debounced_pressed) begin
        if (!st.debounce_active) begin
          st.debounce_active  = 1'b1;
          st.debounce_elapsed = '0;
        end else begin
          st.debounce_elapsed = sat_inc(st.debounce_elapsed);
        end
        if (st.debounce_elapsed >= cfg_i.debounce_ticks) begin
          st.debounced_pressed = pin_down;
          st.debounce_active   = 1'b0;
          st.debounce_elapsed  = '0;
          edge_fire            = 1'b1;
          if (pin_down) begin
            st.hold_active  = 1'b1;
            st.hold_elapsed = '0;
            st.action_done  = 1'b0;
          end else if (st.hold_active) begin
            // Release reports only when the hold fallback has not fired yet.
            if (!st.action_done) begin
              if (st.hold_elapsed >= cfg_i.long_press_ticks) begin
                long_fire = 1'b1;
              end else begin
                short_fire = 1'b1;
              end
            end
            st.hold_active  = 1'b0;
            st.hold_elapsed = '0;
            st.action_done  = 1'b0;
          end
        end
      end else begin
        st.debounce_active  = 1'b0;
        st.debounce_elapsed = '0;
      end

      if (st.debounced_pressed && st.hold_active && !st.action_done) begin
        priority if (st.hold_elapsed >= cfg_i.long_press_ticks) begin
          long_fire      = 1'b1;
          fb_fire        = 1'b1;
          st.action_done = 1'b1;
        end else if (st.hold_elapsed >= cfg_i.short_fallback_ticks) begin
          short_fire     = 1'b1;
          fb_fire        = 1'b1;
          st.action_done = 1'b1;
        end
      end
    end
  end

  assign state_o             = st;
  assign out_o.pressed       = st.debounced_pressed;
  assign out_o.edge_res      = edge_fire;
  assign out_o.short_press   = short_fire;
  assign out_o.long_press    = long_fire;
  assign out_o.from_fallback = fb_fire;

endmodule

@@ hdl/button_press_classifier_top.sv @@
`timescale 1ns / 1ps

// Debounces an active-low button sampled once per millisecond tick and classifies
// each press as short or long, with a hold fallback that fires once while the
// button stays down. One tick is taken per clock cycle: the whole step runs in
// a single combinational pass from the state registers into a result register,
// so a result appears in the cycle after its tick is accepted and a new tick is
// taken every cycle as long as the result register is empty or being drained.
// Users write thresholds via the register port with no tick in flight; not enforced.
module button_press_classifier_top
  import bpc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  bpc_in_t                in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output bpc_out_t               out_data_o
);

  bpc_cfg_t   cfg_q;
  bpc_state_t state_q;
  bpc_state_t state_d;
  bpc_out_t   res_d;
  bpc_out_t   res_q;
  logic       res_valid_q;
  logic       in_fire;

  assign in_ready_o = !res_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks       <= DebounceTicksRst;
      cfg_q.long_press_ticks     <= LongPressTicksRst;
      cfg_q.short_fallback_ticks <= ShortFbTicksRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE_TICKS:   cfg_q.debounce_ticks       <= cfg_data_i;
        CFG_LONG_PRESS_TICKS: cfg_q.long_press_ticks     <= cfg_data_i;
        CFG_SHORT_FB_TICKS:   cfg_q.short_fallback_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bpc_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .in_i    (in_data_i),
    .state_o (state_d),
    .out_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire) begin
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

`ifndef NO_ASSERTIONS
  // A hold count runs exactly while the debounced state is pressed.
  a_hold_tracks_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.hold_active == state_q.debounced_pressed)
    else $error("hold_active out of step with debounced state");

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.short_press && out_data_o.long_press))
    else $error("short and long action in one transaction");

  a_fallback_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.from_fallback) |->
      (out_data_o.pressed && (out_data_o.short_press || out_data_o.long_press)))
    else $error("fallback flag without a held action");

  a_action_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (!state_q.action_done || state_q.hold_active))
    else $error("action_done set without an active hold");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import bpc_pkg::*;

  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned RandomTicks = 1600;
  localparam int unsigned IdlePct     = 19;
  localparam int unsigned MaxPrints   = 40;
  localparam int unsigned ExtremeHoldTicks = 120;
  localparam int unsigned ExtremeDebTicks  = 100;

  // Index 3 has no register behind it; writes there must be dropped.
  localparam logic [CfgIdxWidth-1:0] CfgIdxSpare = CfgIdxWidth'(3);

  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;
  logic                   cfg_we_i   = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i  = '0;
  logic [CfgWidth-1:0]    cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  bpc_in_t                in_data_i  = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  bpc_out_t               out_data_o;

  // Thresholds as the block should currently hold them.
  logic [CfgWidth-1:0] debounce_lim = 16'd30;
  logic [CfgWidth-1:0] long_lim     = 16'd5000;
  logic [CfgWidth-1:0] fallback_lim = 16'd1200;

  // Button state as the block should currently hold it.
  logic                  btn_down   = 1'b0;
  logic                  settling   = 1'b0;
  logic [CountWidth-1:0] settle_cnt = '0;
  logic                  holding    = 1'b0;
  logic [CountWidth-1:0] hold_cnt   = '0;
  logic                  fired      = 1'b0;

  bpc_out_t predicted_out[$];

  int unsigned errors       = 0;
  int unsigned ticks_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned n_edges      = 0;
  int unsigned n_short      = 0;
  int unsigned n_long       = 0;
  int unsigned n_fallback   = 0;
  int unsigned n_loads      = 0;
  int unsigned cycle_count  = 0;
  bit          stall_on     = 1'b1;

  typedef struct {
    bit                     is_cfg;
    logic [CfgIdxWidth-1:0] idx;
    logic [CfgWidth-1:0]    val;
    bpc_in_t                tick;
    bit                     typed;
    bpc_out_t               want;
  } plan_row_t;

  plan_row_t plan[$];

  button_press_classifier_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("FAIL");
    $finish;
  end

  function automatic logic [CountWidth-1:0] bump(logic [CountWidth-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Advances the button state by one tick and returns what the block should report.
  function automatic bpc_out_t classify_tick(bpc_in_t t);
    bpc_out_t r;
    logic     raw_down;
    r = '0;
    raw_down = ~t.pin_level;
    if (!t.ready_req) begin
      btn_down   = 1'b0;
      settling   = 1'b0;
      settle_cnt = '0;
      holding    = 1'b0;
      hold_cnt   = '0;
      fired      = 1'b0;
    end else begin
      if (holding) hold_cnt = bump(hold_cnt);
      if (raw_down != btn_down) begin
        if (!settling) begin
          settling   = 1'b1;
          settle_cnt = '0;
        end else begin
          settle_cnt = bump(settle_cnt);
        end
        if (settle_cnt >= debounce_lim) begin
          btn_down   = raw_down;
          settling   = 1'b0;
          settle_cnt = '0;
          r.edge_res = 1'b1;
          if (btn_down) begin
            holding  = 1'b1;
            hold_cnt = '0;
            fired    = 1'b0;
          end else if (holding) begin
            // A release classifies the press only if the fallback stayed quiet.
            if (!fired) begin
              if (hold_cnt >= long_lim) r.long_press = 1'b1;
              else r.short_press = 1'b1;
            end
            holding  = 1'b0;
            hold_cnt = '0;
            fired    = 1'b0;
          end
        end
      end else begin
        settling   = 1'b0;
        settle_cnt = '0;
      end
      if (btn_down && holding && !fired) begin
        if (hold_cnt >= long_lim) begin
          r.long_press    = 1'b1;
          r.from_fallback = 1'b1;
          fired           = 1'b1;
        end else if (hold_cnt >= fallback_lim) begin
          r.short_press   = 1'b1;
          r.from_fallback = 1'b1;
          fired           = 1'b1;
        end
      end
    end
    r.pressed = btn_down;
    return r;
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= MaxPrints) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_bit(string name, logic got, logic want);
    if (got !== want) begin
      report($sformatf("result %0d: %s is %b, should be %b", results_seen, name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    bpc_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (predicted_out.size() == 0) begin
          report($sformatf("result %0d (%b) arrived with nothing pending", results_seen,
                           out_data_o));
        end else begin
          want = predicted_out.pop_front();
          check_bit("pressed", out_data_o.pressed, want.pressed);
          check_bit("edge_res", out_data_o.edge_res, want.edge_res);
          check_bit("short_press", out_data_o.short_press, want.short_press);
          check_bit("long_press", out_data_o.long_press, want.long_press);
          check_bit("from_fallback", out_data_o.from_fallback, want.from_fallback);
          n_edges    += want.edge_res;
          n_short    += want.short_press;
          n_long     += want.long_press;
          n_fallback += want.from_fallback;
        end
      end
      out_ready_i <= !stall_on || ($urandom_range(99) >= IdlePct);
    end
  end

  // Hands one tick to the block; a typed expectation overrides the predictor's.
  task automatic send_tick(bpc_in_t t, bit typed, bpc_out_t want);
    bpc_out_t pred;
    while (stall_on && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    pred = classify_tick(t);
    predicted_out.push_back(typed ? want : pred);
    ticks_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (predicted_out.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] val, bit last);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_DEBOUNCE_TICKS:   debounce_lim = val;
      CFG_LONG_PRESS_TICKS: long_lim     = val;
      CFG_SHORT_FB_TICKS:   fallback_lim = val;
      default: ;
    endcase
    if (last) cfg_we_i <= 1'b0;
  endtask

  task automatic load_thresholds(logic [CfgWidth-1:0] deb, logic [CfgWidth-1:0] lng,
                                 logic [CfgWidth-1:0] sht);
    drain();
    write_reg(CFG_DEBOUNCE_TICKS, deb, 1'b0);
    write_reg(CFG_LONG_PRESS_TICKS, lng, 1'b0);
    write_reg(CFG_SHORT_FB_TICKS, sht, 1'b0);
    write_reg(CfgIdxSpare, CfgWidth'($urandom), 1'b1);
    n_loads++;
  endtask

  task automatic drive_level(bit pin, int n, bit noisy);
    bpc_in_t t;
    repeat (n) begin
      t.ready_req = !(noisy && $urandom_range(99) < 2);
      t.pin_level = pin;
      send_tick(t, 1'b0, '0);
    end
  endtask

  // Mostly clean presses with contact bounce on both edges; the rest is line noise.
  task automatic run_press();
    bpc_in_t t;
    if ($urandom_range(99) < 80) begin
      drive_level(1'b1, $urandom_range(0, 3), 1'b1);
      repeat ($urandom_range(0, 2)) begin
        drive_level(1'b0, $urandom_range(1, 3), 1'b1);
        drive_level(1'b1, 1, 1'b1);
      end
      drive_level(1'b0, int'(debounce_lim) + 1 + $urandom_range(0, int'(long_lim) + 8), 1'b1);
      repeat ($urandom_range(0, 2)) begin
        drive_level(1'b1, $urandom_range(1, 3), 1'b1);
        drive_level(1'b0, 1, 1'b1);
      end
      drive_level(1'b1, int'(debounce_lim) + 1 + $urandom_range(0, 3), 1'b1);
    end else begin
      repeat ($urandom_range(1, 10)) begin
        t.ready_req = 1'($urandom_range(1));
        t.pin_level = 1'($urandom_range(1));
        send_tick(t, 1'b0, '0);
      end
    end
  endtask

  function automatic plan_row_t tick_row(bit rdy, bit pin, bit typed, bpc_out_t want);
    plan_row_t r;
    r.is_cfg         = 1'b0;
    r.idx            = '0;
    r.val            = '0;
    r.tick.ready_req = rdy;
    r.tick.pin_level = pin;
    r.typed          = typed;
    r.want           = want;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] val);
    plan_row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    r.tick   = '0;
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  initial begin
    int base;
    int stop;
    int phase;

    // Result bits below read: pressed, edge, short, long, fallback.
    // Reset thresholds: nothing can commit within a few ticks.
    plan.push_back(tick_row(1'b0, 1'b0, 1'b1, bpc_out_t'(5'b00000)));
    plan.push_back(tick_row(1'b1, 1'b1, 1'b1, bpc_out_t'(5'b00000)));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b1, bpc_out_t'(5'b00000)));
    plan.push_back(tick_row(1'b0, 1'b0, 1'b1, bpc_out_t'(5'b00000)));
    // Zero debounce: press and release commit on their first tick.
    plan.push_back(reg_row(CFG_DEBOUNCE_TICKS, 16'd0));
    plan.push_back(reg_row(CFG_LONG_PRESS_TICKS, 16'd3));
    plan.push_back(reg_row(CFG_SHORT_FB_TICKS, 16'd1));
    plan.push_back(reg_row(CfgIdxSpare, 16'hFFFF));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b1, bpc_out_t'(5'b11000)));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b1, bpc_out_t'(5'b10101)));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b1, bpc_out_t'(5'b10000)));
    plan.push_back(tick_row(1'b1, 1'b1, 1'b1, bpc_out_t'(5'b01000)));
    // A zero fallback threshold fires in the press tick itself.
    plan.push_back(reg_row(CFG_SHORT_FB_TICKS, 16'd0));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b1, bpc_out_t'(5'b11101)));
    plan.push_back(tick_row(1'b1, 1'b1, 1'b1, bpc_out_t'(5'b01000)));
    // The long threshold wins when it is not above the short one.
    plan.push_back(reg_row(CFG_LONG_PRESS_TICKS, 16'd0));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b1, bpc_out_t'(5'b11011)));
    plan.push_back(tick_row(1'b1, 1'b1, 1'b1, bpc_out_t'(5'b01000)));
    // Release classification, long and then short.
    plan.push_back(reg_row(CFG_LONG_PRESS_TICKS, 16'd2));
    plan.push_back(reg_row(CFG_SHORT_FB_TICKS, 16'd10));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b1, bpc_out_t'(5'b11000)));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b1, bpc_out_t'(5'b10000)));
    plan.push_back(tick_row(1'b1, 1'b1, 1'b1, bpc_out_t'(5'b01010)));
    plan.push_back(reg_row(CFG_LONG_PRESS_TICKS, 16'd5));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b1, bpc_out_t'(5'b11000)));
    plan.push_back(tick_row(1'b1, 1'b1, 1'b1, bpc_out_t'(5'b01100)));
    // A bounce cancels the count, which then restarts from zero.
    plan.push_back(reg_row(CFG_DEBOUNCE_TICKS, 16'd2));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b0, '0));
    plan.push_back(tick_row(1'b1, 1'b1, 1'b0, '0));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b0, '0));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b0, '0));
    plan.push_back(tick_row(1'b1, 1'b0, 1'b0, '0));
    plan.push_back(tick_row(1'b0, 1'b1, 1'b1, bpc_out_t'(5'b00000)));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (i == 0 || !plan[i-1].is_cfg) drain();
        write_reg(plan[i].idx, plan[i].val, i + 1 == plan.size() || !plan[i+1].is_cfg);
      end else begin
        send_tick(plan[i].tick, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under its own thresholds. One phase runs with no idling.
    base  = ticks_sent;
    phase = 0;
    while (ticks_sent - base < RandomTicks) begin
      if (phase % 5 == 0) load_thresholds('0, '0, '0);
      else load_thresholds(CfgWidth'($urandom_range(0, 4)), CfgWidth'($urandom_range(0, 40)),
                           CfgWidth'($urandom_range(0, 40)));
      stall_on = (phase != 3);
      stop = ticks_sent + $urandom_range(150, 300);
      while (ticks_sent < stop) run_press();
      phase++;
    end
    stall_on = 1'b1;

    // Full-scale hold thresholds: no fallback fires, and the release reports short.
    load_thresholds('0, '1, '1);
    drive_level(1'b0, ExtremeHoldTicks, 1'b0);
    drive_level(1'b1, 2, 1'b0);

    // Full-scale debounce: a long stretch of a differing level never commits.
    load_thresholds('1, '0, '0);
    drive_level(1'b0, ExtremeDebTicks, 1'b0);
    drive_level(1'b1, 1, 1'b1);
    send_tick('0, 1'b0, '0);

    drain();
    repeat (8) @(posedge clk_i);

    $display("Ran %0d ticks under %0d threshold settings plus the directed table.",
             ticks_sent, n_loads);
    $display("Saw %0d debounced edges, %0d short and %0d long actions, %0d by hold fallback.",
             n_edges, n_short, n_long, n_fallback);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
